// ----- rtl/hhecl_pkg.sv -----
// ----------------------------------------------------------------------------
// hhecl_pkg
// Shared types and constants for the HTTP header-end / Content-Length scanner.
// ----------------------------------------------------------------------------
package hhecl_pkg;

    // Width of the length_value port.
    localparam int LEN_OUT_W = 24;

    // Per-byte status carried from the scan core to the result register
    typedef struct packed {
        logic done;
        logic body;
        logic extra;
        logic length_found;
    } step_flags_t;

endpackage

// ----- rtl/hhecl_core.sv -----
// ----------------------------------------------------------------------------
// hhecl_core
// Parser state and one-byte next-state logic for the header/length scanner.
// ----------------------------------------------------------------------------
module hhecl_core #(
    parameter int LEN_BITS = 24
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      step,
    input  logic [7:0]                data_byte,
    input  logic                      restart,
    output hhecl_pkg::step_flags_t    flags,
    output logic [LEN_BITS-1:0]       length_acc
);

    localparam logic [4:0] PH_SKIP_EMPTY  = 5'd0;
    localparam logic [4:0] PH_SKIP        = 5'd1;
    localparam logic [4:0] PH_LF          = 5'd2;
    localparam logic [4:0] PH_LFCR        = 5'd3;
    localparam logic [4:0] PH_STARTWS     = 5'd4;
    localparam logic [4:0] PH_NAME_FIRST  = 5'd5;
    localparam logic [4:0] PH_NAME_LAST   = 5'd17;
    localparam logic [4:0] PH_COLON       = 5'd18;
    localparam logic [4:0] PH_VALUE_START = 5'd19;
    localparam logic [4:0] PH_VALUE       = 5'd20;
    localparam logic [4:0] PH_BODY        = 5'd21;

    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SP     = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LOW_C  = 8'h63;
    localparam logic [7:0] CH_LOW_L  = 8'h6C;
    localparam logic [7:0] CASE_BIT  = 8'h20;

    // Header name after the leading 'c': "ontent-length"
    function automatic logic [7:0] name_char(input logic [3:0] k);
        logic [7:0] ch;
        unique case (k)
            4'd0:    ch = 8'h6F;
            4'd1:    ch = 8'h6E;
            4'd2:    ch = 8'h74;
            4'd3:    ch = 8'h65;
            4'd4:    ch = 8'h6E;
            4'd5:    ch = 8'h74;
            4'd6:    ch = CH_DASH;
            4'd7:    ch = 8'h6C;
            4'd8:    ch = 8'h65;
            4'd9:    ch = 8'h6E;
            4'd10:   ch = 8'h67;
            4'd11:   ch = 8'h74;
            4'd12:   ch = 8'h68;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Phase after the first byte of a header line
    function automatic logic [4:0] line_start(input logic [7:0] b, input logic lv,
                                              input logic [4:0] dflt);
        logic [4:0] ph;
        ph = dflt;
        if (b == CH_SP || b == CH_TAB)
            ph = lv ? PH_SKIP : PH_STARTWS;
        else if ((b | CASE_BIT) == CH_LOW_C)
            ph = lv ? PH_SKIP : PH_NAME_FIRST;
        else if ((b | CASE_BIT) == CH_LOW_L)
            ph = lv ? PH_SKIP : PH_COLON;
        else if (b == CH_LF)
            ph = PH_LF;
        return ph;
    endfunction

    logic [4:0]          phase_reg,    phase_next;
    logic [LEN_BITS-1:0] accum_reg,    accum_next;
    logic                valid_reg,    valid_next;
    logic [LEN_BITS-1:0] remain_reg,   remain_next;
    logic                finished_reg, finished_next;

    logic [4:0]          ph_cur;
    logic [LEN_BITS-1:0] acc_cur;
    logic                lv_cur;
    logic [LEN_BITS-1:0] rem_cur;
    logic                fin_cur;

    logic                is_digit;
    logic [3:0]          digit;
    logic [LEN_BITS+3:0] acc_wide;
    logic [LEN_BITS+3:0] prod;
    logic [LEN_BITS-1:0] acc_sat;
    logic [3:0]          name_idx;
    logic [7:0]          want;
    logic                hit;
    logic [LEN_BITS-1:0] rem_dec;
    logic                done;
    logic                body;
    logic                extra;

    // Restart applies the reset state before this byte
    assign ph_cur  = restart ? PH_SKIP_EMPTY : phase_reg;
    assign acc_cur = restart ? '0 : accum_reg;
    assign lv_cur  = restart ? 1'b0 : valid_reg;
    assign rem_cur = restart ? '0 : remain_reg;
    assign fin_cur = restart ? 1'b0 : finished_reg;

    assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
    assign digit    = data_byte[3:0];

    // accum * 10 + digit, saturated
    assign acc_wide = {4'b0000, acc_cur};
    assign prod     = (acc_wide << 3) + (acc_wide << 1) + {{LEN_BITS{1'b0}}, digit};
    assign acc_sat  = (prod[LEN_BITS+3:LEN_BITS] != 4'd0) ? '1 : prod[LEN_BITS-1:0];

    assign name_idx = 4'(ph_cur - PH_NAME_FIRST);
    assign want     = name_char(name_idx);
    assign hit      = (want == CH_DASH) ? (data_byte == CH_DASH || data_byte == CH_USCORE)
                                        : ((data_byte | CASE_BIT) == want);

    assign rem_dec = (rem_cur != '0) ? rem_cur - {{(LEN_BITS-1){1'b0}}, 1'b1} : '0;

    always_comb
    begin
        phase_next    = ph_cur;
        accum_next    = acc_cur;
        valid_next    = lv_cur;
        remain_next   = rem_cur;
        finished_next = fin_cur;
        done          = 1'b0;
        body          = 1'b0;
        extra         = 1'b0;

        priority if (fin_cur)
        begin
            extra = 1'b1;
        end
        else if (ph_cur >= PH_NAME_FIRST && ph_cur <= PH_NAME_LAST)
        begin
            if (hit)
                phase_next = (ph_cur == PH_NAME_LAST) ? PH_COLON : ph_cur + 5'd1;
            else
                phase_next = (data_byte == CH_LF) ? PH_LF : PH_SKIP;
        end
        else
        begin
            unique case (ph_cur)
                PH_SKIP_EMPTY:
                begin
                    if (!(data_byte == CH_LF || data_byte == CH_CR ||
                          data_byte == CH_SP || data_byte == CH_TAB))
                    begin
                        if ((data_byte | CASE_BIT) == CH_LOW_C)
                            phase_next = PH_NAME_FIRST;
                        else if ((data_byte | CASE_BIT) == CH_LOW_L)
                            phase_next = PH_COLON;
                        else
                            phase_next = PH_SKIP;
                    end
                end
                PH_LF, PH_LFCR:
                begin
                    if (ph_cur == PH_LF && data_byte == CH_CR)
                        phase_next = PH_LFCR;
                    else if (data_byte == CH_LF)
                    begin
                        // End of headers: enter body or finish now
                        phase_next = PH_BODY;
                        if (lv_cur && acc_cur != '0)
                            remain_next = acc_cur;
                        else
                        begin
                            remain_next   = '0;
                            finished_next = 1'b1;
                            done          = 1'b1;
                        end
                    end
                    else if (ph_cur == PH_LF)
                        phase_next = line_start(data_byte, lv_cur, PH_SKIP);
                    else
                        phase_next = PH_SKIP;
                end
                PH_STARTWS:
                begin
                    phase_next = line_start(data_byte, lv_cur, PH_SKIP);
                end
                PH_COLON:
                begin
                    if (!(data_byte == CH_SP || data_byte == CH_TAB))
                    begin
                        if (data_byte == CH_COLON)
                            phase_next = PH_VALUE_START;
                        else
                            phase_next = (data_byte == CH_LF) ? PH_LF : PH_SKIP;
                    end
                end
                PH_VALUE_START:
                begin
                    if (!(data_byte == CH_SP || data_byte == CH_TAB))
                    begin
                        if (is_digit)
                        begin
                            accum_next = {{(LEN_BITS-4){1'b0}}, digit};
                            phase_next = PH_VALUE;
                        end
                        else
                            phase_next = (data_byte == CH_LF) ? PH_LF : PH_SKIP;
                    end
                end
                PH_VALUE:
                begin
                    if (is_digit)
                        accum_next = acc_sat;
                    else if (data_byte == CH_CR || data_byte == CH_SP ||
                             data_byte == CH_TAB)
                    begin
                        valid_next = 1'b1;
                        phase_next = PH_SKIP;
                    end
                    else if (data_byte == CH_LF)
                    begin
                        valid_next = 1'b1;
                        phase_next = PH_LF;
                    end
                    else
                        phase_next = PH_SKIP;
                end
                PH_BODY:
                begin
                    body        = 1'b1;
                    remain_next = rem_dec;
                    if (rem_dec == '0)
                    begin
                        finished_next = 1'b1;
                        done          = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = (data_byte == CH_LF) ? PH_LF : PH_SKIP;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_SKIP_EMPTY;
            accum_reg    <= '0;
            valid_reg    <= 1'b0;
            remain_reg   <= '0;
            finished_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            accum_reg    <= accum_next;
            valid_reg    <= valid_next;
            remain_reg   <= remain_next;
            finished_reg <= finished_next;
        end
    end

    assign flags.done         = done;
    assign flags.body         = body;
    assign flags.extra        = extra;
    assign flags.length_found = valid_next;
    assign length_acc         = accum_next;

endmodule

// ----- rtl/http_header_end_content_length_scanner_top.sv -----
// ----------------------------------------------------------------------------
// http_header_end_content_length_scanner_top
// Byte-wide scanner that finds the end of an HTTP header block, parses the
// Content-Length value and counts the body down to message completion.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake            | Payload
//  --------+----------------------+------------------------------------------
//  input   | in_valid / in_stall  | data_byte, restart
//  output  | out_valid / out_stall| message_done, in_body, length_found,
//          |                      | length_value, extra_byte
//
//  One byte per cycle sustained while out_stall is low; every transaction gives
//  exactly one result, via the input register and then the result register.
//  The rate is set by the parser state loop in hhecl_core: byte classification,
//  multiply-by-ten accumulate with saturation and phase update are combinational.
//  rst_n clears the parser to the skip-blank-lines phase with no length.
//  out_stall holds the result register; the input register then holds too
//  and in_stall rises, so no transaction is dropped.
//
module http_header_end_content_length_scanner_top #(
    parameter int LEN_BITS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        restart,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        message_done,
    output logic        in_body,
    output logic        length_found,
    output logic [hhecl_pkg::LEN_OUT_W-1:0] length_value,
    output logic        extra_byte
);

    localparam int OW = hhecl_pkg::LEN_OUT_W;

    // Input register
    logic        s1_valid_reg, s1_valid_next;
    logic [7:0]  s1_byte_reg;
    logic        s1_restart_reg;

    // Result register
    logic                   out_valid_reg, out_valid_next;
    hhecl_pkg::step_flags_t out_flags_reg;
    logic [OW-1:0]          out_len_reg;

    logic                   out_free;
    logic                   s1_go;
    logic                   accept;
    hhecl_pkg::step_flags_t core_flags;
    logic [LEN_BITS-1:0]    core_len;
    logic [LEN_BITS+OW-1:0] len_ext;

    // Result register can load when empty or being taken this cycle
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_go    = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign accept   = in_valid && !in_stall;

    assign s1_valid_next  = in_stall ? 1'b1 : accept;
    assign out_valid_next = s1_go ? 1'b1 : (out_valid_reg && out_stall);

    // Advance the parser state only when the byte moves into the result register
    hhecl_core #(
        .LEN_BITS (LEN_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (s1_go),
        .data_byte  (s1_byte_reg),
        .restart    (s1_restart_reg),
        .flags      (core_flags),
        .length_acc (core_len)
    );

    // Report the low bits of the accumulator, zero-extended if it is narrower
    assign len_ext = {{OW{1'b0}}, core_len};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: load on transfer, hold otherwise
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_byte_reg    <= data_byte;
            s1_restart_reg <= restart;
        end
        if (s1_go)
        begin
            out_flags_reg <= core_flags;
            out_len_reg   <= len_ext[OW-1:0];
        end
    end

    assign out_valid    = out_valid_reg;
    assign message_done = out_flags_reg.done;
    assign in_body      = out_flags_reg.body;
    assign length_found = out_flags_reg.length_found;
    assign length_value = out_len_reg;
    assign extra_byte   = out_flags_reg.extra;

`ifndef SYNTH
    // A byte after completion is never body or a completion
    a_extra_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_flags_reg.extra &&
                            (out_flags_reg.body || out_flags_reg.done)))
        else $error("extra byte flagged as body or completion");

    // A held input byte stays in the input register
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_free) |=> (s1_valid_reg && $stable(s1_byte_reg)))
        else $error("input register lost a stalled byte");

    // A stalled result stays valid and unchanged
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(out_len_reg)))
        else $error("result register changed under stall");
`endif

endmodule
